// File: sv/bed_pkg.sv
package bed_pkg;

    localparam int BED_FIFO_DEPTH = 4;
    localparam int BED_PTR_W      = $clog2(BED_FIFO_DEPTH);
    localparam int BED_CNT_W      = $clog2(BED_FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       stop;
        logic       last;
    } t_bed_result;

    typedef struct packed {
        logic [1:0]  num;
        t_bed_result r0;
        t_bed_result r1;
    } t_bed_push;

endpackage

// File: sv/bed_decode.sv
module bed_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [7:0]         i_in_byte,
    input  logic               i_end_of_arg,
    output bed_pkg::t_bed_push o_push
);
    import bed_pkg::*;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_OCTAL  = 2'd2
    } t_mode;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;

    t_mode       r_mode;
    t_mode       n_mode;
    logic [7:0]  r_oval;
    logic [7:0]  n_oval;
    logic [1:0]  r_odig;
    logic [1:0]  n_odig;
    logic        r_halted;
    logic        n_halted;

    logic [1:0]  num;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic        stop0;
    logic        is_oct;
    logic [7:0]  oct_next;
    logic [1:0]  dig_next;

    assign is_oct   = (i_in_byte >= CH_ZERO) && (i_in_byte <= CH_SEVEN);
    assign oct_next = {r_oval[4:0], i_in_byte[2:0]};
    assign dig_next = r_odig + 2'd1;

    always_comb begin
        n_mode   = r_mode;
        n_oval   = r_oval;
        n_odig   = r_odig;
        n_halted = r_halted;
        num      = 2'd0;
        byte0    = 8'h00;
        byte1    = 8'h00;
        stop0    = 1'b0;
        if (!r_halted) begin
            unique case (r_mode)
                MODE_ESCAPE: begin
                    n_mode = MODE_NORMAL;
                    num    = 2'd1;
                    unique case (i_in_byte)
                        CH_BSLASH: byte0 = 8'h5C;
                        CH_A:      byte0 = 8'h07;
                        CH_B:      byte0 = 8'h08;
                        CH_F:      byte0 = 8'h0C;
                        CH_N:      byte0 = 8'h0A;
                        CH_R:      byte0 = 8'h0D;
                        CH_T:      byte0 = 8'h09;
                        CH_V:      byte0 = 8'h0B;
                        CH_C: begin
                            stop0    = 1'b1;
                            n_halted = 1'b1;
                        end
                        CH_ZERO: begin
                            n_oval = 8'h00;
                            n_odig = 2'd0;
                            if (!i_end_of_arg) begin
                                num    = 2'd0;
                                n_mode = MODE_OCTAL;
                            end
                        end
                        default: begin
                            num   = 2'd2;
                            byte0 = CH_BSLASH;
                            byte1 = i_in_byte;
                        end
                    endcase
                end
                MODE_OCTAL: begin
                    if (is_oct) begin
                        n_oval = oct_next;
                        n_odig = dig_next;
                        if (dig_next == 2'd3 || i_end_of_arg) begin
                            num    = 2'd1;
                            byte0  = oct_next;
                            n_mode = MODE_NORMAL;
                        end
                    end else begin
                        num    = 2'd1;
                        byte0  = r_oval;
                        n_mode = MODE_NORMAL;
                        if (i_in_byte == CH_BSLASH) begin
                            if (!i_end_of_arg) begin
                                n_mode = MODE_ESCAPE;
                            end
                        end else begin
                            num   = 2'd2;
                            byte1 = i_in_byte;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_NORMAL;
                    if (i_in_byte == CH_BSLASH) begin
                        if (!i_end_of_arg) begin
                            n_mode = MODE_ESCAPE;
                        end
                    end else begin
                        num   = 2'd1;
                        byte0 = i_in_byte;
                    end
                end
            endcase
            if (i_end_of_arg && !n_halted) begin
                n_mode = MODE_NORMAL;
            end
            if (n_mode != MODE_OCTAL) begin
                n_oval = 8'h00;
                n_odig = 2'd0;
            end
        end
    end

    assign o_push.num         = num;
    assign o_push.r0.out_byte = byte0;
    assign o_push.r0.stop     = stop0;
    assign o_push.r0.last     = (num == 2'd1);
    assign o_push.r1.out_byte = byte1;
    assign o_push.r1.stop     = 1'b0;
    assign o_push.r1.last     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_oval   <= 8'h00;
            r_odig   <= 2'd0;
            r_halted <= 1'b0;
        end else if (i_en) begin
            r_mode   <= n_mode;
            r_oval   <= n_oval;
            r_odig   <= n_odig;
            r_halted <= n_halted;
        end
    end

    a_halted_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("Halted flag cleared without reset.");

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (num == 2'd0))
        else $error("Results produced after a stop.");

    a_octal_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_OCTAL) |-> (r_odig == 2'd0 && r_oval == 8'h00))
        else $error("Octal run not cleared outside octal mode.");

endmodule

// File: sv/backslash_escape_decoder_core.sv
// Backslash escape decoder.
// Input channel: i_valid, o_stall, i_in_byte, i_end_of_arg. A transaction
// completes on a rising edge with i_valid high and o_stall low. One byte of
// an argument string is taken per transaction, with i_end_of_arg on the
// final byte.
// Output channel: o_valid, i_stall, o_out_byte, o_stop, o_last. Each input
// transaction gives zero, one or two output transactions; o_last marks the
// final one. A stop escape gives one transaction with o_stop set and a zero
// byte, and every later input byte is consumed without output until reset.
// Results are registered in a four-entry result queue ahead of the output.
// Throughput is one input byte per cycle while each byte yields at most one
// result and the receiver does not stall; a byte that yields two results
// adds two to the queue, which the single output port drains one at a time.
// o_stall rises when fewer than two queue entries are free, so it depends
// only on registered state. When the receiver stalls, the queue fills and the
// input channel is stalled in turn; no result is lost.
// Reset is synchronous and active low; it empties the queue and returns the
// decoder to normal mode with no escape pending and the stop cleared.
module backslash_escape_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_arg,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_stop,
    output logic       o_last
);
    import bed_pkg::*;

    t_bed_push                push;
    logic                     in_acc;
    logic                     pop;
    t_bed_result              r_mem [BED_FIFO_DEPTH];
    logic [BED_PTR_W-1:0]     r_wptr;
    logic [BED_PTR_W-1:0]     r_rptr;
    logic [BED_CNT_W-1:0]     r_count;
    logic [BED_CNT_W-1:0]     n_count;
    logic [1:0]               push_num;
    t_bed_result              head;

    assign o_stall  = (r_count > BED_CNT_W'(BED_FIFO_DEPTH - 2));
    assign in_acc   = i_valid && !o_stall;
    assign push_num = in_acc ? push.num : 2'd0;
    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && !i_stall;
    assign head     = r_mem[r_rptr];

    assign o_out_byte = head.out_byte;
    assign o_stop     = head.stop;
    assign o_last     = head.last;

    assign n_count = r_count + BED_CNT_W'(push_num) - BED_CNT_W'(pop);

    bed_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_acc),
        .i_in_byte    (i_in_byte),
        .i_end_of_arg (i_end_of_arg),
        .o_push       (push)
    );

    always_ff @(posedge i_clk) begin
        if (push_num != 2'd0) begin
            r_mem[r_wptr] <= push.r0;
        end
        if (push_num == 2'd2) begin
            r_mem[r_wptr + BED_PTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + BED_PTR_W'(push_num);
            r_rptr  <= r_rptr + BED_PTR_W'(pop);
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= BED_CNT_W'(BED_FIFO_DEPTH))
        else $error("Result queue overflow.");

    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && push.num != 2'd0) |=> o_valid)
        else $error("Accepted result not presented.");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_count == BED_CNT_W'(1) && push_num == 2'd0) |=> !o_valid)
        else $error("Queue not empty after last result left.");

    a_stop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stop) |-> (o_last && o_out_byte == 8'h00))
        else $error("Stop result malformed.");

endmodule

// File: dv/tb_backslash_escape_decoder_core.sv
module tb_backslash_escape_decoder_core;
    import bed_pkg::*;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_A      = "a";
    localparam logic [7:0] CH_B      = "b";
    localparam logic [7:0] CH_C      = "c";
    localparam logic [7:0] CH_F      = "f";
    localparam logic [7:0] CH_N      = "n";
    localparam logic [7:0] CH_R      = "r";
    localparam logic [7:0] CH_T      = "t";
    localparam logic [7:0] CH_V      = "v";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_SEVEN  = "7";
    localparam logic [7:0] CTL_BEL   = 8'h07;
    localparam logic [7:0] CTL_BS    = 8'h08;
    localparam logic [7:0] CTL_HT    = 8'h09;
    localparam logic [7:0] CTL_LF    = 8'h0A;
    localparam logic [7:0] CTL_VT    = 8'h0B;
    localparam logic [7:0] CTL_FF    = 8'h0C;
    localparam logic [7:0] CTL_CR    = 8'h0D;
    localparam logic [7:0] ESC_LETTERS [8] =
        '{CH_BSLASH, CH_A, CH_B, CH_F, CH_N, CH_R, CH_T, CH_V};

    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {
        DEC_PLAIN,
        DEC_BSLASH,
        DEC_OCTAL
    } t_dec_mode;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_in_byte    = 8'h00;
    logic       i_end_of_arg = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_stop;
    logic       o_last;

    t_dec_mode   dec_mode   = DEC_PLAIN;
    logic [7:0]  oct_value  = 8'h00;
    logic [1:0]  oct_digits = 2'd0;
    logic        dec_halted = 1'b0;
    t_bed_result expected_bytes [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 0;
    int n_items        = 0;
    int n_results      = 0;
    int n_stops        = 0;
    int n_errors       = 0;

    backslash_escape_decoder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_end_of_arg (i_end_of_arg),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_stop       (o_stop),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic void emit(input logic [7:0] b, input logic s);
        expected_bytes.push_back('{out_byte: b, stop: s, last: 1'b0});
    endfunction

    function automatic void pass_plain(input logic [7:0] b, input logic e);
        if (b == CH_BSLASH) begin
            if (!e) begin
                dec_mode = DEC_BSLASH;
            end
        end else begin
            emit(b, 1'b0);
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic e);
        int          n0;
        t_bed_result r;
        n0 = expected_bytes.size();
        if (dec_halted) begin
            return;
        end
        case (dec_mode)
            DEC_BSLASH: begin
                dec_mode = DEC_PLAIN;
                case (b)
                    CH_BSLASH: emit(CH_BSLASH, 1'b0);
                    CH_A:      emit(CTL_BEL, 1'b0);
                    CH_B:      emit(CTL_BS, 1'b0);
                    CH_F:      emit(CTL_FF, 1'b0);
                    CH_N:      emit(CTL_LF, 1'b0);
                    CH_R:      emit(CTL_CR, 1'b0);
                    CH_T:      emit(CTL_HT, 1'b0);
                    CH_V:      emit(CTL_VT, 1'b0);
                    CH_C: begin
                        emit(8'h00, 1'b1);
                        dec_halted = 1'b1;
                    end
                    CH_ZERO: begin
                        oct_value  = 8'h00;
                        oct_digits = 2'd0;
                        if (e) begin
                            emit(8'h00, 1'b0);
                        end else begin
                            dec_mode = DEC_OCTAL;
                        end
                    end
                    default: begin
                        emit(CH_BSLASH, 1'b0);
                        emit(b, 1'b0);
                    end
                endcase
            end
            DEC_OCTAL: begin
                if (b >= CH_ZERO && b <= CH_SEVEN) begin
                    oct_value  = oct_value * 8'd8 + (b - CH_ZERO);
                    oct_digits = oct_digits + 2'd1;
                    if (oct_digits == 2'd3 || e) begin
                        emit(oct_value, 1'b0);
                        dec_mode = DEC_PLAIN;
                    end
                end else begin
                    emit(oct_value, 1'b0);
                    dec_mode = DEC_PLAIN;
                    pass_plain(b, e);
                end
            end
            default: pass_plain(b, e);
        endcase
        if (e && !dec_halted) begin
            dec_mode = DEC_PLAIN;
        end
        if (dec_mode != DEC_OCTAL) begin
            oct_value  = 8'h00;
            oct_digits = 2'd0;
        end
        if (expected_bytes.size() > n0) begin
            r = expected_bytes.pop_back();
            r.last = 1'b1;
            expected_bytes.push_back(r);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic e);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_in_byte    <= b;
        i_end_of_arg <= e;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        decode_byte(b, e);
        n_items++;
    endtask

    // Random traffic must never halt the decoder, so a stop escape is replaced.
    task automatic send_open_byte(input logic [7:0] b, input logic e);
        if (dec_mode == DEC_BSLASH && b == CH_C) begin
            b = CH_N;
        end
        send_byte(b, e);
    endtask

    task automatic send_random_token();
        int kind;
        int ndig;
        kind = $urandom_range(15);
        if (kind <= 4) begin
            send_open_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
        end else if (kind <= 8) begin
            send_open_byte(CH_BSLASH, 1'b0);
            send_open_byte(ESC_LETTERS[3'($urandom_range(7))], $urandom_range(9) == 0);
        end else if (kind <= 11) begin
            send_open_byte(CH_BSLASH, 1'b0);
            send_open_byte(CH_ZERO, $urandom_range(11) == 0);
            ndig = $urandom_range(4);
            repeat (ndig) begin
                send_open_byte(CH_ZERO + 8'($urandom_range(7)), $urandom_range(9) == 0);
            end
        end else if (kind <= 13) begin
            send_open_byte(CH_BSLASH, 1'b0);
            send_open_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
        end else if (kind == 14) begin
            send_open_byte(CH_BSLASH, 1'b1);
        end else begin
            repeat ($urandom_range(1, 6)) begin
                send_open_byte(8'($urandom_range(255)), 1'b0);
            end
            send_open_byte(8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (expected_bytes.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_bytes.size() > 0) begin
            $display("%0d expected transactions never arrived", expected_bytes.size());
            n_errors += expected_bytes.size();
            expected_bytes.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic report(input string what, input t_bed_result want,
                          input t_bed_result got);
        n_errors++;
        if (n_errors <= 10) begin
            $display("%s: expected byte %02h stop %0b last %0b, got byte %02h stop %0b last %0b",
                     what, want.out_byte, want.stop, want.last,
                     got.out_byte, got.stop, got.last);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_bed_result got;
        t_bed_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{out_byte: o_out_byte, stop: o_stop, last: o_last};
            n_results++;
            if (o_stop) begin
                n_stops++;
            end
            if (expected_bytes.size() == 0) begin
                report("Unexpected transaction", '0, got);
            end else begin
                want = expected_bytes.pop_front();
                if (got.out_byte !== want.out_byte || got.stop !== want.stop
                        || got.last !== want.last) begin
                    report("Mismatch", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
        end
        i_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
    end

    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_drained();
    endtask

    task automatic test_control_escapes();
        foreach (ESC_LETTERS[i]) begin
            send_byte(CH_BSLASH, 1'b0);
            send_byte(ESC_LETTERS[i], i == 7);
        end
        wait_drained();
    endtask

    task automatic test_unknown_escapes();
        send_byte(CH_BSLASH, 1'b0);
        send_byte("q", 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(CH_BSLASH, 1'b1);
        wait_drained();
    endtask

    task automatic test_octal_runs();
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_ZERO, 1'b0);
        repeat (3) send_byte(CH_SEVEN, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_ZERO, 1'b0);
        send_byte("1", 1'b0);
        send_byte("x", 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_ZERO, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_N, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_ZERO, 1'b0);
        send_byte("5", 1'b1);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_ZERO, 1'b1);
        wait_drained();
    endtask

    task automatic run_mix(input int idle_pct, input int stall_pct, input int count);
        int goal;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal = n_items + count;
        while (n_items < goal) begin
            send_random_token();
        end
        wait_drained();
    endtask

    task automatic test_no_idling();
        run_mix(0, 0, 170);
    endtask

    task automatic test_sender_gaps();
        run_mix(77, 0, 170);
    endtask

    task automatic test_receiver_stalls();
        run_mix(0, 77, 170);
    endtask

    task automatic test_both_idle();
        run_mix(13, 13, 170);
    endtask

    task automatic test_receiver_hold();
        int goal;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        goal = n_items + 40;
        while (n_items < goal) begin
            send_random_token();
        end
        wait_drained();
    endtask

    task automatic test_stop_escape();
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        send_byte("z", 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_C, 1'b0);
        send_byte("A", 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_N, 1'b1);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_ZERO, 1'b0);
        send_byte("3", 1'b1);
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_bytes();
        test_control_escapes();
        test_unknown_escapes();
        test_octal_runs();
        test_no_idling();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_receiver_hold();
        test_stop_escape();
        $display("Decoded %0d input bytes into %0d output transactions (%0d stop),",
                 n_items, n_results, n_stops);
        $display("covering all escapes, octal runs, idle and stall mixes and a long hold.");
        if (n_errors == 0) begin
            $display("** backslash_escape_decoder_core: PASSED **");
        end else begin
            $display("%0d errors found.", n_errors);
            $display("** backslash_escape_decoder_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation timed out.");
        $display("** backslash_escape_decoder_core: FAILED **");
        $finish;
    end

endmodule
